### hw/rtl/bilinear_table_interpolator_defines.svh
// assertion macros for the bilinear table interpolator
// used by the modules that carry concurrent checks, no other dependencies
`ifndef BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bti assertion failed");
`define BTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bti assertion failed");
`else
`define BTI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bti_pkg.sv
// shared types and constants of the bilinear table interpolator
// no dependencies
`timescale 1ns / 1ps

package bti_pkg;

    localparam int CNT_W  = 5;
    localparam int FRAC_W = 16;
    localparam int WGT_W  = FRAC_W + 1;
    localparam int OUT_W  = 16;
    localparam int IN_W   = 16;
    localparam int ADDR_W = 5;

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(16);

    // multiply sequence steps
    localparam logic [CNT_W-1:0] STEP_RD11  = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_RD12  = CNT_W'(1);
    localparam logic [CNT_W-1:0] STEP_RD21  = CNT_W'(2);
    localparam logic [CNT_W-1:0] STEP_RD22  = CNT_W'(3);
    localparam logic [CNT_W-1:0] STEP_ROW2  = CNT_W'(4);
    localparam logic [CNT_W-1:0] STEP_ACC2  = CNT_W'(5);
    localparam logic [CNT_W-1:0] STEP_MULF1 = CNT_W'(6);
    localparam logic [CNT_W-1:0] STEP_MULF2 = CNT_W'(7);
    localparam logic [CNT_W-1:0] STEP_SUM   = CNT_W'(8);

    typedef enum logic [1:0] {
        KIND_FORCE = 2'd0,
        KIND_VEL   = 2'd1,
        KIND_TABLE = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FSCAN,
        S_FDIVI,
        S_FDIV,
        S_VSCAN,
        S_VDIVI,
        S_VDIV,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             load;
        logic             write;
        logic             scan;
        logic             div_init;
        logic             div_step;
        logic             div_last;
        logic             axis_v;
        logic             mul;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

endpackage

### hw/rtl/bti_entry_ram.sv
// table entry memory, one write port and one registered read port
// per-entry valid bits give zero for entries not written since reset
`timescale 1ns / 1ps

module bti_entry_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bti_datapath.sv
// datapath: axis points, bracket search, serial divider, corner blend
// depends on bti_pkg and bti_entry_ram
`timescale 1ns / 1ps

module bti_datapath #(
    parameter int FORCE_POINTS    = 5,
    parameter int VELOCITY_POINTS = 9,
    parameter int VALUE_WIDTH     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bti_pkg::t_dp_cmd                 i_cmd,
    input  bti_pkg::t_kind                   i_kind,
    input  logic [bti_pkg::ADDR_W-1:0]       i_address,
    input  logic [bti_pkg::IN_W-1:0]         i_write_value,
    input  logic signed [bti_pkg::IN_W-1:0]  i_force_req,
    input  logic signed [bti_pkg::IN_W-1:0]  i_velocity,
    output logic [bti_pkg::OUT_W-1:0]        o_error_power
);

    import bti_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int ENTRIES = (FORCE_POINTS - 1) * (VELOCITY_POINTS - 1);
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW      = (VW > IN_W) ? VW : IN_W;
    localparam int XW      = BW + 2;
    localparam int RW      = VW + FRAC_W;
    localparam int PW      = RW + WGT_W;
    localparam int SW      = BW + 2 * FRAC_W + 1;

    logic [VW-1:0] r_force_pts [FORCE_POINTS-1];
    logic [VW-1:0] r_vel_pts [VELOCITY_POINTS-1];

    logic signed [XW-1:0] r_xf, r_xv;
    logic [CNT_W-1:0]     r_lo, r_hi;
    logic [VW-1:0]        r_p_lo, r_p_hi;
    logic                 r_run, r_prev_ge;
    logic [VW:0]          r_rem;
    logic [VW-1:0]        r_den;
    logic                 r_zero;
    logic [WGT_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_f1, r_f2, r_v1, r_v2;
    logic [WGT_W-1:0]     r_wf, r_wv;
    logic                 r_corner_zero;
    logic [RW-1:0]        r_row1, r_row2;
    logic [PW-1:0]        r_prod;
    logic [SW-1:0]        r_sum;
    logic [OUT_W-1:0]     r_error_power;

    logic [VW-1:0]        p_sel;
    logic signed [XW-1:0] x_sel, p_ext, p_lo_ext, p_hi_ext, den_full, num_full, num_cl;
    logic                 le, ge, zero_n;
    logic [VW:0]          trial, n_rem;
    logic                 take;
    logic [WGT_W-1:0]     n_q, w_fin;
    logic [WGT_W-1:0]     wf_lo, wv_lo;
    logic [CNT_W-1:0]     row, col;
    logic [31:0]          lin;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [VW-1:0]        rdata, entry;
    logic [RW-1:0]        mul_a;
    logic [WGT_W-1:0]     mul_b;
    logic [PW-1:0]        mul_full;

    // axis point stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < FORCE_POINTS - 1; j++) r_force_pts[j] <= '0;
            for (int j = 0; j < VELOCITY_POINTS - 1; j++) r_vel_pts[j] <= '0;
        end else if (i_cmd.write) begin
            for (int j = 0; j < FORCE_POINTS - 1; j++) begin
                if (i_kind == KIND_FORCE && 32'(i_address) == 32'(j)) begin
                    r_force_pts[j] <= VW'(i_write_value);
                end
            end
            for (int j = 0; j < VELOCITY_POINTS - 1; j++) begin
                if (i_kind == KIND_VEL && 32'(i_address) == 32'(j)) begin
                    r_vel_pts[j] <= VW'(i_write_value);
                end
            end
        end
    end

    // point and query under test
    always_comb begin
        p_sel = '0;
        for (int j = 0; j < FORCE_POINTS - 1; j++) begin
            if (!i_cmd.axis_v && i_cmd.idx == CNT_W'(j + 1)) p_sel = r_force_pts[j];
        end
        for (int j = 0; j < VELOCITY_POINTS - 1; j++) begin
            if (i_cmd.axis_v && i_cmd.idx == CNT_W'(j + 1)) p_sel = r_vel_pts[j];
        end
        x_sel    = i_cmd.axis_v ? r_xv : r_xf;
        p_ext    = $signed({{(XW - VW){1'b0}}, p_sel});
        p_lo_ext = $signed({{(XW - VW){1'b0}}, r_p_lo});
        p_hi_ext = $signed({{(XW - VW){1'b0}}, r_p_hi});
        le       = p_ext <= x_sel;
        ge       = p_ext >= x_sel;
        den_full = p_hi_ext - p_lo_ext;
        num_full = x_sel - p_lo_ext;
        zero_n   = (r_lo == r_hi) || (den_full <= 0);
        if (num_full < 0) begin
            num_cl = '0;
        end else if (num_full > den_full) begin
            num_cl = den_full;
        end else begin
            num_cl = num_full;
        end
    end

    // divider step
    always_comb begin
        trial = (i_cmd.idx == '0) ? r_rem : {r_rem[VW-1:0], 1'b0};
        take  = trial >= {1'b0, r_den};
        n_rem = take ? (trial - {1'b0, r_den}) : trial;
        n_q   = {r_q[WGT_W-2:0], take};
        w_fin = r_zero ? '0 : n_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xf <= XW'(i_force_req);
            r_xv <= XW'(i_velocity);
        end
        if (i_cmd.scan) begin
            if (i_cmd.idx == '0) begin
                r_lo      <= '0;
                r_hi      <= '0;
                r_p_lo    <= '0;
                r_p_hi    <= '0;
                r_run     <= 1'b1;
                r_prev_ge <= ge;
            end else begin
                if (r_run && le) begin
                    r_lo   <= i_cmd.idx;
                    r_p_lo <= p_sel;
                end else begin
                    r_run <= 1'b0;
                end
                if (!(r_prev_ge && ge)) begin
                    r_hi   <= i_cmd.idx;
                    r_p_hi <= p_sel;
                end
                r_prev_ge <= ge;
            end
        end
        if (i_cmd.div_init) begin
            r_rem  <= {1'b0, num_cl[VW-1:0]};
            r_den  <= den_full[VW-1:0];
            r_zero <= zero_n;
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            if (i_cmd.div_last) begin
                if (i_cmd.axis_v) begin
                    r_wv <= w_fin;
                    r_v1 <= r_lo;
                    r_v2 <= r_hi;
                end else begin
                    r_wf <= w_fin;
                    r_f1 <= r_lo;
                    r_f2 <= r_hi;
                end
            end
        end
    end

    // corner fetch
    always_comb begin
        case (i_cmd.idx)
            STEP_RD11: begin
                row = r_f1;
                col = r_v1;
            end
            STEP_RD12: begin
                row = r_f1;
                col = r_v2;
            end
            STEP_RD21: begin
                row = r_f2;
                col = r_v1;
            end
            default: begin
                row = r_f2;
                col = r_v2;
            end
        endcase
        lin   = (32'(row) - 32'd1) * 32'(VELOCITY_POINTS - 1) + 32'(col) - 32'd1;
        raddr = AW'(lin);
        we    = i_cmd.write && i_kind == KIND_TABLE && 32'(i_address) < 32'(ENTRIES);
    end

    bti_entry_ram #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .DW    (VW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (AW'(i_address)),
        .i_wdata (VW'(i_write_value)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // multiplier operands
    always_comb begin
        entry = r_corner_zero ? '0 : rdata;
        wf_lo = ONE_Q16 - r_wf;
        wv_lo = ONE_Q16 - r_wv;
        case (i_cmd.idx)
            STEP_RD12: begin
                mul_a = RW'(entry);
                mul_b = wv_lo;
            end
            STEP_RD21: begin
                mul_a = RW'(entry);
                mul_b = r_wv;
            end
            STEP_RD22: begin
                mul_a = RW'(entry);
                mul_b = wv_lo;
            end
            STEP_ROW2: begin
                mul_a = RW'(entry);
                mul_b = r_wv;
            end
            STEP_MULF1: begin
                mul_a = r_row1;
                mul_b = wf_lo;
            end
            STEP_MULF2: begin
                mul_a = r_row2;
                mul_b = r_wf;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // products are registered in r_prod before they are accumulated
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_corner_zero <= (row == '0) || (col == '0);
            r_prod        <= mul_full;
            case (i_cmd.idx)
                STEP_RD21:  r_row1 <= RW'(r_prod);
                STEP_RD22:  r_row1 <= r_row1 + RW'(r_prod);
                STEP_ROW2:  r_row2 <= RW'(r_prod);
                STEP_ACC2:  r_row2 <= r_row2 + RW'(r_prod);
                STEP_MULF2: r_sum  <= SW'(r_prod);
                STEP_SUM:   r_sum  <= r_sum + SW'(r_prod);
                default:    r_sum  <= r_sum;
            endcase
        end
        if (i_cmd.out_load) begin
            r_error_power <= r_sum[2 * FRAC_W +: OUT_W];
        end
    end

    assign o_error_power = r_error_power;

endmodule

### hw/rtl/bti_ctrl.sv
// controller: sequences scan, divide and blend steps, owns the handshakes
// depends on bti_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "bilinear_table_interpolator_defines.svh"

module bti_ctrl #(
    parameter int FORCE_POINTS    = 5,
    parameter int VELOCITY_POINTS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bti_pkg::t_kind    i_kind,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bti_pkg::t_dp_cmd  o_cmd
);

    import bti_pkg::*;

    localparam logic [CNT_W-1:0] F_LAST = CNT_W'(FORCE_POINTS - 1);
    localparam logic [CNT_W-1:0] V_LAST = CNT_W'(VELOCITY_POINTS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept, out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_cmd.idx   = r_cnt;
        o_in_stall  = (r_state != S_IDLE);
        accept      = i_in_valid && !o_in_stall;
        out_busy    = r_out_valid && i_out_stall;
        n_out_valid = out_busy;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_state    = S_FSCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_FSCAN, S_VSCAN: begin
                o_cmd.scan   = 1'b1;
                o_cmd.axis_v = (r_state == S_VSCAN);
                if (r_cnt == ((r_state == S_VSCAN) ? V_LAST : F_LAST)) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_VSCAN) ? S_VDIVI : S_FDIVI;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_FDIVI, S_VDIVI: begin
                o_cmd.div_init = 1'b1;
                o_cmd.axis_v   = (r_state == S_VDIVI);
                n_cnt          = '0;
                n_state        = (r_state == S_VDIVI) ? S_VDIV : S_FDIV;
            end
            S_FDIV, S_VDIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.axis_v   = (r_state == S_VDIV);
                if (r_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_cnt          = '0;
                    n_state        = (r_state == S_VDIV) ? S_MUL : S_VSCAN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_cnt == STEP_SUM) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `BTI_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && i_kind == KIND_QUERY, r_state == S_FSCAN)
    `BTI_ASSERT_NEXT(a_write_stays, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && i_kind != KIND_QUERY, r_state == S_IDLE)
    `BTI_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, r_state == S_DONE && !(r_out_valid && i_out_stall), r_state == S_IDLE && r_out_valid)
    `BTI_ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)

endmodule

### hw/rtl/bilinear_table_interpolator.sv
// top level of the bilinear table interpolator
// depends on bti_pkg, bti_ctrl and bti_datapath
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  kind, address, write_value, force_req, velocity
//   out      output     o_out_valid / i_out_stall  error_power
//
// a write is done in the idle state; a query runs one axis scan step per point and a 17-step
// serial divider once per axis, then nine steps on the shared corner multiplier.
// reset clears axes and table at once. a finished result waits in the output
// register and a new item is taken meanwhile; only its result waits on i_out_stall.
`timescale 1ns / 1ps

module bilinear_table_interpolator #(
    parameter int FORCE_POINTS    = 5,
    parameter int VELOCITY_POINTS = 9,
    parameter int VALUE_WIDTH     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [bti_pkg::ADDR_W-1:0]       i_address,
    input  logic [bti_pkg::IN_W-1:0]         i_write_value,
    input  logic signed [bti_pkg::IN_W-1:0]  i_force_req,
    input  logic signed [bti_pkg::IN_W-1:0]  i_velocity,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bti_pkg::OUT_W-1:0]        o_error_power
);

    import bti_pkg::*;

    t_dp_cmd cmd;
    t_kind   kind;

    assign kind = t_kind'(i_kind);

    bti_ctrl #(
        .FORCE_POINTS    (FORCE_POINTS),
        .VELOCITY_POINTS (VELOCITY_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bti_datapath #(
        .FORCE_POINTS    (FORCE_POINTS),
        .VELOCITY_POINTS (VELOCITY_POINTS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (kind),
        .i_address     (i_address),
        .i_write_value (i_write_value),
        .i_force_req   (i_force_req),
        .i_velocity    (i_velocity),
        .o_error_power (o_error_power)
    );

endmodule

### bench/bilinear_table_interpolator_checker.sv
// checker for the bilinear table interpolator: watches both channels, predicts, compares
// depends on bti_pkg
`timescale 1ns / 1ps

module bilinear_table_interpolator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_address,
    input  logic [15:0] i_write_value,
    input  logic [15:0] i_force_req,
    input  logic [15:0] i_velocity,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_error_power,
    output int          o_fail_count,
    output int          o_pending
);
    import bti_pkg::*;

    logic [15:0] force_axis [4];
    logic [15:0] vel_axis [8];
    logic [15:0] power_tab [32];
    logic [15:0] power_queue [$];

    assign o_pending = power_queue.size();

    function automatic longint axis_pt(bit is_vel, int i);
        if (i == 0) return 0;
        return is_vel ? longint'(vel_axis[i-1]) : longint'(force_axis[i-1]);
    endfunction

    function automatic longint tab_at(int r, int c);
        if (r == 0 || c == 0) return 0;
        return longint'(power_tab[(r-1)*8 + (c-1)]);
    endfunction

    function automatic void find_bracket(input bit is_vel, input longint x,
                                         output int lo, output int hi, output longint w_hi);
        int n;
        longint den;
        longint num;
        n = is_vel ? 9 : 5;
        lo = 0;
        hi = n - 1;
        w_hi = 0;
        while (lo < n - 1 && axis_pt(is_vel, lo + 1) <= x) lo++;
        while (hi > 0 && axis_pt(is_vel, hi) >= x && axis_pt(is_vel, hi - 1) >= x) hi--;
        if (lo == hi) return;
        den = axis_pt(is_vel, hi) - axis_pt(is_vel, lo);
        if (den <= 0) return;
        num = x - axis_pt(is_vel, lo);
        if (num < 0) num = 0;
        if (num > den) num = den;
        w_hi = (num << 16) / den;
    endfunction

    function automatic logic [15:0] interpolate(logic [15:0] f_raw, logic [15:0] v_raw);
        int f1, f2, v1, v2;
        longint wf2, wv2;
        logic [127:0] row1, row2, total;
        find_bracket(1'b0, longint'($signed(f_raw)), f1, f2, wf2);
        find_bracket(1'b1, longint'($signed(v_raw)), v1, v2, wv2);
        row1 = 128'(tab_at(f1, v1) * (65536 - wv2)) + 128'(tab_at(f1, v2) * wv2);
        row2 = 128'(tab_at(f2, v1) * (65536 - wv2)) + 128'(tab_at(f2, v2) * wv2);
        total = row1 * 128'(65536 - wf2) + row2 * 128'(wf2);
        return total[47:32];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (force_axis[i]) force_axis[i] = '0;
            foreach (vel_axis[i]) vel_axis[i] = '0;
            foreach (power_tab[i]) power_tab[i] = '0;
            power_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (power_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected transfer: error_power %0d", i_error_power);
                end else begin
                    if (power_queue[0] !== i_error_power) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("error_power mismatch: expected %0d actual %0d",
                                     power_queue[0], i_error_power);
                    end
                    void'(power_queue.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (t_kind'(i_kind))
                    KIND_FORCE: if (i_address < 4) force_axis[i_address] = i_write_value;
                    KIND_VEL:   if (i_address < 8) vel_axis[i_address] = i_write_value;
                    KIND_TABLE: power_tab[i_address] = i_write_value;
                    KIND_QUERY: power_queue.insert(power_queue.size(),
                                                   interpolate(i_force_req, i_velocity));
                    default: ;
                endcase
            end
        end
    end
endmodule

### bench/bilinear_table_interpolator_test.sv
// stimulus and verdict for the bilinear table interpolator
// depends on bti_pkg, bilinear_table_interpolator and bilinear_table_interpolator_checker
`timescale 1ns / 1ps

module bilinear_table_interpolator_test;
    import bti_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = KIND_QUERY;
    logic [4:0]  address = '0;
    logic [15:0] write_value = '0;
    logic [15:0] force_req = '0;
    logic [15:0] velocity = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] error_power;
    int          fail_count;
    int          pending;
    bit          idle_off = 1'b0;
    bit          hold_out = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bilinear_table_interpolator u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_address(address), .i_write_value(write_value),
        .i_force_req(force_req), .i_velocity(velocity),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_error_power(error_power)
    );

    bilinear_table_interpolator_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_address(address), .i_write_value(write_value),
        .i_force_req(force_req), .i_velocity(velocity),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_error_power(error_power),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls in bursts, or holds off for a long stretch on request
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_out = 1'b0;
                out_stall <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input t_kind k, input logic [4:0] a, input logic [15:0] wv,
                        input logic [15:0] f, input logic [15:0] v);
        if (!idle_off && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        address <= a;
        write_value <= wv;
        force_req <= f;
        velocity <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic load_ascending(input int span);
        int acc;
        acc = 0;
        for (int i = 0; i < 4; i++) begin
            acc += $urandom_range(1, span);
            send(KIND_FORCE, 5'(i), 16'(acc), '0, '0);
        end
        acc = 0;
        for (int i = 0; i < 8; i++) begin
            acc += $urandom_range(1, span);
            send(KIND_VEL, 5'(i), 16'(acc), '0, '0);
        end
    endtask

    task automatic random_query();
        if ($urandom_range(0, 3) == 0)
            send(KIND_QUERY, 5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send(KIND_QUERY, 5'($urandom), 16'($urandom),
                 16'($urandom_range(0, 8000)) - 16'd200,
                 16'($urandom_range(0, 16000)) - 16'd200);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // all-zero stores, extremes of the query fields
        send(KIND_QUERY, 5'd31, 16'hFFFF, 16'h8000, 16'h7FFF);
        send(KIND_QUERY, 5'd0, 16'h0000, 16'h7FFF, 16'h8000);
        send(KIND_FORCE, 5'd0, 16'd100, '0, '0);
        send(KIND_FORCE, 5'd1, 16'd50, '0, '0);
        send(KIND_FORCE, 5'd4, 16'd999, '0, '0);
        send(KIND_VEL, 5'd7, 16'hFFFF, '0, '0);
        send(KIND_VEL, 5'd8, 16'd5, '0, '0);
        send(KIND_VEL, 5'd0, 16'd200, '0, '0);
        send(KIND_TABLE, 5'd0, 16'hFFFF, '0, '0);
        send(KIND_TABLE, 5'd31, 16'hFFFF, '0, '0);
        send(KIND_TABLE, 5'd8, 16'h1234, '0, '0);
        // descending pair, on a point, between points, below and above the axes
        send(KIND_QUERY, '0, '0, 16'd75, 16'd100);
        send(KIND_QUERY, '0, '0, 16'd100, 16'd200);
        send(KIND_QUERY, '0, '0, 16'd50, 16'd0);
        send(KIND_QUERY, '0, '0, 16'hFFFF, 16'hFFF0);
        send(KIND_QUERY, '0, '0, 16'h7FFF, 16'h7FFF);
        send(KIND_QUERY, '0, '0, 16'd30, 16'd150);
        for (int t = 0; t < 32; t++) send(KIND_TABLE, 5'(t), 16'($urandom), '0, '0);
        // random part: sorted axes mostly, random content
        for (int blk = 0; blk < 8; blk++) begin
            if (blk % 3 == 2) begin
                for (int i = 0; i < 6; i++)
                    send(t_kind'($urandom_range(0, 2)), 5'($urandom), 16'($urandom), '0, '0);
            end else begin
                load_ascending(blk % 2 ? 2000 : 8000);
            end
            for (int t = 0; t < 4; t++) send(KIND_TABLE, 5'($urandom), 16'($urandom), '0, '0);
            if (blk == 4) hold_out = 1'b1;
            if (blk == 7) idle_off = 1'b1;
            for (int q = 0; q < 36; q++) random_query();
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
